>>> hdl/mmdp_pkg.sv
// Shared constants, types and sizes of the matrix multiply dot product unit.
`default_nettype none
package mmdp_pkg;

  localparam int MAX_N = 64;
  localparam int IDX_W = $clog2(MAX_N);
  localparam int ADDR_W = $clog2(MAX_N * MAX_N);
  localparam int DEPTH = MAX_N * MAX_N;

  localparam int KIND_W = 2;
  localparam int POS_W = 6;
  localparam int N_W = 7;
  localparam int VAL_W = 32;
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W = PROD_W + $clog2(MAX_N);
  localparam int RND_W = ACC_W - 16;

  localparam logic [N_W-1:0] SIZE_RESET = N_W'(64);

  localparam logic [KIND_W-1:0] KIND_WR_A = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WR_B = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CALC = 2'd2;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [N_W-1:0]   n;
    logic             zero;
  } cmd_t;

  typedef struct packed {
    logic busy;
  } back_status_t;

endpackage
`default_nettype wire

>>> hdl/mmdp_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module mmdp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/mmdp_queue.sv
// Short command queue between the front end and the dot product engine.
`default_nettype none
module mmdp_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire mmdp_pkg::cmd_t push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               empty,
  output mmdp_pkg::cmd_t     head
);

  mmdp_pkg::cmd_t                    mem_r [mmdp_pkg::QDEPTH];
  logic [mmdp_pkg::QPTR_W-1:0]       wptr_r;
  logic [mmdp_pkg::QPTR_W-1:0]       rptr_r;
  logic [mmdp_pkg::QCNT_W-1:0]       count_r;
  logic                              do_push;
  logic                              do_pop;

  assign full    = (count_r == mmdp_pkg::QCNT_W'(mmdp_pkg::QDEPTH));
  assign empty   = (count_r == '0);
  assign head    = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

>>> hdl/mmdp_front.sv
// Front end: input stage, configuration register, store writes and command issue.
`default_nettype none
module mmdp_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire logic [mmdp_pkg::KIND_W-1:0]     in_kind,
  input  wire logic [mmdp_pkg::POS_W-1:0]      in_row,
  input  wire logic [mmdp_pkg::POS_W-1:0]      in_col,
  input  wire logic signed [mmdp_pkg::VAL_W-1:0] in_value,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [mmdp_pkg::N_W-1:0]        cfg_data,
  input  wire mmdp_pkg::back_status_t          back_st,
  input  wire logic                            q_full,
  input  wire logic                            q_empty,
  output logic                                 q_push,
  output mmdp_pkg::cmd_t                       q_data,
  output logic                                 a_we,
  output logic                                 b_we,
  output logic [mmdp_pkg::ADDR_W-1:0]          w_addr,
  output logic [mmdp_pkg::VAL_W-1:0]           w_data
);

  logic                          fr_v_r;
  logic                          fr_v_nxt;
  logic [mmdp_pkg::KIND_W-1:0]   fr_kind_r;
  logic [mmdp_pkg::POS_W-1:0]    fr_row_r;
  logic [mmdp_pkg::POS_W-1:0]    fr_col_r;
  logic [mmdp_pkg::VAL_W-1:0]    fr_val_r;
  logic [mmdp_pkg::N_W-1:0]      msize_r;
  logic [mmdp_pkg::N_W-1:0]      n_eff;
  logic                          pending;
  logic                          go;
  logic                          in_range;
  logic                          accept;

  assign pending   = !q_empty || back_st.busy;
  assign in_range  = (int'(fr_row_r) < mmdp_pkg::MAX_N) && (int'(fr_col_r) < mmdp_pkg::MAX_N);
  assign n_eff     = (int'(msize_r) < mmdp_pkg::MAX_N) ? msize_r
                                                       : mmdp_pkg::N_W'(mmdp_pkg::MAX_N);
  assign cfg_ready = 1'b1;

  always_comb begin
    case (fr_kind_r) inside
      mmdp_pkg::KIND_WR_A, mmdp_pkg::KIND_WR_B: go = !pending;
      mmdp_pkg::KIND_CALC:                      go = !q_full;
      default:                                  go = 1'b1;
    endcase
  end

  assign in_full  = fr_v_r && !go;
  assign accept   = in_push && !in_full;
  assign fr_v_nxt = accept ? 1'b1 : (go ? 1'b0 : fr_v_r);

  assign a_we   = fr_v_r && go && in_range && (fr_kind_r == mmdp_pkg::KIND_WR_A);
  assign b_we   = fr_v_r && go && in_range && (fr_kind_r == mmdp_pkg::KIND_WR_B);
  assign w_data = fr_val_r;

  always_comb begin
    if (fr_kind_r == mmdp_pkg::KIND_WR_A) begin
      w_addr = mmdp_pkg::ADDR_W'(int'(fr_row_r) * mmdp_pkg::MAX_N + int'(fr_col_r));
    end else begin
      w_addr = mmdp_pkg::ADDR_W'(int'(fr_col_r) * mmdp_pkg::MAX_N + int'(fr_row_r));
    end
  end

  assign q_push      = fr_v_r && go && (fr_kind_r == mmdp_pkg::KIND_CALC);
  assign q_data.row  = fr_row_r;
  assign q_data.col  = fr_col_r;
  assign q_data.n    = n_eff;
  assign q_data.zero = (int'(fr_row_r) >= int'(n_eff)) || (int'(fr_col_r) >= int'(n_eff));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_v_r  <= 1'b0;
      msize_r <= mmdp_pkg::SIZE_RESET;
    end else begin
      fr_v_r <= fr_v_nxt;
      if (cfg_valid) begin
        msize_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_kind_r <= in_kind;
      fr_row_r  <= in_row;
      fr_col_r  <= in_col;
      fr_val_r  <= in_value;
    end
  end

endmodule
`default_nettype wire

>>> hdl/mmdp_back.sv
// Back end: multiply-accumulate sequencer, rounding, saturation and result register.
`default_nettype none
module mmdp_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_empty,
  input  wire mmdp_pkg::cmd_t                q_data,
  output logic                               q_pop,
  output logic [mmdp_pkg::ADDR_W-1:0]        a_raddr,
  output logic [mmdp_pkg::ADDR_W-1:0]        b_raddr,
  input  wire logic [mmdp_pkg::VAL_W-1:0]    a_rdata,
  input  wire logic [mmdp_pkg::VAL_W-1:0]    b_rdata,
  output mmdp_pkg::back_status_t             st,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic signed [mmdp_pkg::VAL_W-1:0]  out_product,
  output logic                               out_overflow
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_ROUND = 5'b01000,
    S_SAT   = 5'b10000
  } state_t;

  state_t                               state_r;
  state_t                               state_nxt;
  mmdp_pkg::cmd_t                       cmd_r;
  logic [mmdp_pkg::IDX_W-1:0]           k_r;
  logic                                 v1_r;
  logic                                 v2_r;
  logic signed [mmdp_pkg::PROD_W-1:0]   prod_r;
  logic signed [mmdp_pkg::ACC_W-1:0]    acc_r;
  logic signed [mmdp_pkg::ACC_W-1:0]    acc_rnd;
  logic [mmdp_pkg::RND_W-1:0]           rnd_r;
  logic                                 res_v_r;
  logic [mmdp_pkg::VAL_W-1:0]           res_prod_r;
  logic                                 res_ovf_r;
  logic                                 issue;
  logic                                 k_last;
  logic                                 load_res;
  logic [mmdp_pkg::RND_W-1:31]          upper;
  logic                                 sat_ovf;
  logic [mmdp_pkg::VAL_W-1:0]           sat_val;

  assign issue   = (state_r == S_READ);
  assign k_last  = (int'(k_r) + 1 == int'(cmd_r.n));
  assign q_pop   = (state_r == S_IDLE) && !q_empty && !res_v_r;
  assign a_raddr = mmdp_pkg::ADDR_W'(int'(cmd_r.row) * mmdp_pkg::MAX_N + int'(k_r));
  assign b_raddr = mmdp_pkg::ADDR_W'(int'(cmd_r.col) * mmdp_pkg::MAX_N + int'(k_r));

  assign st.busy = (state_r != S_IDLE);

  assign acc_rnd = acc_r + mmdp_pkg::ACC_W'(32768);
  assign upper   = rnd_r[mmdp_pkg::RND_W-1:31];
  assign sat_ovf = !((&upper) || !(|upper));
  assign sat_val = sat_ovf ? (rnd_r[mmdp_pkg::RND_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                           : rnd_r[31:0];

  assign load_res = (q_pop && q_data.zero) || (state_r == S_SAT);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_pop && !q_data.zero) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (k_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!v1_r && !v2_r) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: state_nxt = S_SAT;
      S_SAT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= issue;
      v2_r    <= v1_r;
      if (load_res) begin
        res_v_r <= 1'b1;
      end else if (out_pop) begin
        res_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_data;
      k_r   <= '0;
      acc_r <= '0;
    end else begin
      if (issue) begin
        k_r <= k_r + 1'b1;
      end
      if (v2_r) begin
        acc_r <= acc_r + {{(mmdp_pkg::ACC_W - mmdp_pkg::PROD_W){prod_r[mmdp_pkg::PROD_W-1]}},
                          prod_r};
      end
    end
    if (v1_r) begin
      prod_r <= $signed(a_rdata) * $signed(b_rdata);
    end
    if (state_r == S_ROUND) begin
      rnd_r <= acc_rnd[mmdp_pkg::ACC_W-1:16];
    end
    if (load_res) begin
      if (state_r == S_SAT) begin
        res_prod_r <= sat_val;
        res_ovf_r  <= sat_ovf;
      end else begin
        res_prod_r <= '0;
        res_ovf_r  <= 1'b0;
      end
    end
  end

  assign out_empty    = !res_v_r;
  assign out_product  = res_prod_r;
  assign out_overflow = res_ovf_r;

endmodule
`default_nettype wire

>>> hdl/matrix_multiply_dot_product_unit.sv
// Top level of the matrix multiply dot product unit.
// The input channel is a queue write port: a transaction is taken at a clock edge with
// in_push high and in_full low. Kind 0 writes A[row][col], kind 1 writes B[row][col]
// (row is the inner index), kind 2 asks for C[row][col], kind 3 is dropped.
// The result channel is a queue read port: out_product and out_overflow are valid while
// out_empty is low, and the transaction completes on an edge with out_pop high.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) sets the matrix order n; it
// is always ready. Write it only while the unit is idle; the unit does not check this.
// A write item waits in the input stage while any compute is still pending so that
// every compute sees the stores as they stood when it arrived.
// A compute item runs n multiply-accumulate steps through one 32x32 multiplier fed by
// one read port of each store. Out-of-range computes return zero. A four-entry command
// queue lets later items be taken while the engine is busy.
// A held result that is not popped stops the engine; the queue then fills and in_full
// rises. Reset clears all control state and sets n to 64; store contents are left as
// they are, are not cleared and need no clearing pass.
`default_nettype none
module matrix_multiply_dot_product_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_push,
  output logic                                   in_full,
  input  wire logic [mmdp_pkg::KIND_W-1:0]       in_kind,
  input  wire logic [mmdp_pkg::POS_W-1:0]        in_row,
  input  wire logic [mmdp_pkg::POS_W-1:0]        in_col,
  input  wire logic signed [mmdp_pkg::VAL_W-1:0] in_value,
  output logic                                   out_empty,
  input  wire logic                              out_pop,
  output logic signed [mmdp_pkg::VAL_W-1:0]      out_product,
  output logic                                   out_overflow,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [mmdp_pkg::N_W-1:0]          cfg_data
);

  mmdp_pkg::back_status_t            back_st;
  mmdp_pkg::cmd_t                    q_wdata;
  mmdp_pkg::cmd_t                    q_head;
  logic                              q_push;
  logic                              q_pop;
  logic                              q_full;
  logic                              q_empty;
  logic                              a_we;
  logic                              b_we;
  logic [mmdp_pkg::ADDR_W-1:0]       w_addr;
  logic [mmdp_pkg::VAL_W-1:0]        w_data;
  logic [mmdp_pkg::ADDR_W-1:0]       a_raddr;
  logic [mmdp_pkg::ADDR_W-1:0]       b_raddr;
  logic [mmdp_pkg::VAL_W-1:0]        a_rdata;
  logic [mmdp_pkg::VAL_W-1:0]        b_rdata;

  mmdp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_kind   (in_kind),
    .in_row    (in_row),
    .in_col    (in_col),
    .in_value  (in_value),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .back_st   (back_st),
    .q_full    (q_full),
    .q_empty   (q_empty),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .a_we      (a_we),
    .b_we      (b_we),
    .w_addr    (w_addr),
    .w_data    (w_data)
  );

  mmdp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  mmdp_ram #(
    .WIDTH (mmdp_pkg::VAL_W),
    .DEPTH (mmdp_pkg::DEPTH)
  ) u_a_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (w_addr),
    .wdata (w_data),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mmdp_ram #(
    .WIDTH (mmdp_pkg::VAL_W),
    .DEPTH (mmdp_pkg::DEPTH)
  ) u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (w_addr),
    .wdata (w_data),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  mmdp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_data       (q_head),
    .q_pop        (q_pop),
    .a_raddr      (a_raddr),
    .b_raddr      (b_raddr),
    .a_rdata      (a_rdata),
    .b_rdata      (b_rdata),
    .st           (back_st),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_product  (out_product),
    .out_overflow (out_overflow)
  );

endmodule
`default_nettype wire
